[hdl/dtp_pkg.sv]
// Shared types and constants for the DER TLV stream parser.
// No dependencies; imported by dtp_decode, dtp_skid and der_tlv_stream_parser.
package dtp_pkg;

   // longest long-form length field, in bytes after the 0x8N byte
   localparam int unsigned MAX_LEN_BYTES = 4;

   // length byte codes
   localparam logic [7:0] LEN_INDEF    = 8'h80;
   localparam logic [7:0] LEN_LONG_MIN = 8'h81;
   localparam logic [7:0] LEN_LONG_MAX = 8'(LEN_INDEF + MAX_LEN_BYTES);

   // header length values
   localparam logic [2:0] HDR_LEN_TAG   = 3'd1;
   localparam logic [2:0] HDR_LEN_SHORT = 3'd2;

   typedef enum logic [1:0] {
      PH_IDENT,
      PH_LEN1,
      PH_LENX,
      PH_DATA
   } phase_type;

   typedef enum logic [2:0] {
      KIND_HDR,
      KIND_DONE,
      KIND_KEEP,
      KIND_STRIP,
      KIND_ERR
   } kind_type;

   // parser state carried from beat to beat
   typedef struct packed {
      phase_type   phase;
      logic [7:0]  ident;
      logic [31:0] length_acc;
      logic [2:0]  len_left;
      logic [2:0]  hdr_len;
      logic [31:0] content_left;
      logic        lead_zeros;
   } state_type;

   // one result beat
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  out_byte;
      logic [1:0]  tag_class;
      logic        constructed;
      logic [4:0]  tag_number;
      logic [31:0] content_length;
      logic [2:0]  header_length;
      logic        last;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:        PH_IDENT,
      ident:        8'h00,
      length_acc:   32'h0,
      len_left:     3'd0,
      hdr_len:      3'd0,
      content_left: 32'h0,
      lead_zeros:   1'b1
   };

endpackage

[hdl/dtp_decode.sv]
// Per-byte TLV decode: next parser state and the result beat for one input byte.
// Depends on dtp_pkg.
module dtp_decode (
   input  dtp_pkg::state_type  st,
   input  logic                strip_zeros,
   input  logic [7:0]          data_byte,
   output dtp_pkg::state_type  st_nxt,
   output dtp_pkg::result_type res
);
   import dtp_pkg::*;

   logic [31:0] acc_shift;
   logic [31:0] cont_dec;
   logic        cont_final;
   logic        strip;
   logic        long_ok;
   logic        len_end;
   phase_type   phase_nxt;
   kind_type    kind;
   logic        last;
   logic        hdr_valid;

   // shared datapath terms
   assign acc_shift  = {st.length_acc[23:0], data_byte};
   assign cont_dec   = st.content_left - {31'h0, (st.content_left != 32'h0)};
   assign cont_final = (cont_dec == 32'h0);
   assign strip      = strip_zeros && st.lead_zeros && (data_byte == 8'h00) && !cont_final;
   assign long_ok    = data_byte inside {[LEN_LONG_MIN:LEN_LONG_MAX]};
   assign len_end    = (st.len_left <= 3'd1);

   // next phase
   always_comb begin
      phase_nxt = st.phase;
      case (st.phase)
         PH_IDENT: phase_nxt = PH_LEN1;
         PH_LEN1: begin
            if (data_byte < LEN_INDEF) begin
               phase_nxt = (data_byte == 8'h00) ? PH_IDENT : PH_DATA;
            end else if (long_ok) begin
               phase_nxt = PH_LENX;
            end else begin
               phase_nxt = PH_IDENT;
            end
         end
         PH_LENX: begin
            if (len_end) begin
               phase_nxt = (acc_shift == 32'h0) ? PH_IDENT : PH_DATA;
            end else begin
               phase_nxt = PH_LENX;
            end
         end
         PH_DATA: phase_nxt = cont_final ? PH_IDENT : PH_DATA;
         default: phase_nxt = PH_IDENT;
      endcase
   end

   // datapath update and result kind
   always_comb begin
      st_nxt.phase        = phase_nxt;
      st_nxt.ident        = st.ident;
      st_nxt.length_acc   = st.length_acc;
      st_nxt.len_left     = st.len_left;
      st_nxt.hdr_len      = st.hdr_len;
      st_nxt.content_left = st.content_left;
      st_nxt.lead_zeros   = st.lead_zeros;
      kind                = KIND_HDR;
      last                = 1'b0;
      case (st.phase)
         PH_IDENT: begin
            st_nxt.ident      = data_byte;
            st_nxt.hdr_len    = HDR_LEN_TAG;
            st_nxt.length_acc = 32'h0;
            st_nxt.len_left   = 3'd0;
         end
         PH_LEN1: begin
            st_nxt.hdr_len = HDR_LEN_SHORT;
            if (data_byte < LEN_INDEF) begin
               st_nxt.length_acc = {24'h0, data_byte};
               kind              = KIND_DONE;
               if (data_byte == 8'h00) begin
                  last = 1'b1;
               end else begin
                  st_nxt.content_left = {24'h0, data_byte};
                  st_nxt.lead_zeros   = 1'b1;
               end
            end else if (long_ok) begin
               st_nxt.len_left   = 3'(data_byte - LEN_INDEF);
               st_nxt.length_acc = 32'h0;
            end else begin
               kind = KIND_ERR;
               last = 1'b1;
            end
         end
         PH_LENX: begin
            st_nxt.length_acc = acc_shift;
            st_nxt.hdr_len    = st.hdr_len + 3'd1;
            if (len_end) begin
               st_nxt.len_left = 3'd0;
               kind            = KIND_DONE;
               if (acc_shift == 32'h0) begin
                  last = 1'b1;
               end else begin
                  st_nxt.content_left = acc_shift;
                  st_nxt.lead_zeros   = 1'b1;
               end
            end else begin
               st_nxt.len_left = st.len_left - 3'd1;
            end
         end
         PH_DATA: begin
            st_nxt.content_left = cont_dec;
            if (!strip) begin
               st_nxt.lead_zeros = 1'b0;
            end
            kind = strip ? KIND_STRIP : KIND_KEEP;
            last = cont_final;
         end
         default: begin
            kind = KIND_ERR;
            last = 1'b1;
         end
      endcase
   end

   // result fields come from the updated header
   assign hdr_valid = (kind == KIND_DONE) || (kind == KIND_KEEP) || (kind == KIND_STRIP);

   always_comb begin
      res.kind           = kind;
      res.out_byte       = data_byte;
      res.tag_class      = hdr_valid ? st_nxt.ident[7:6] : 2'd0;
      res.constructed    = hdr_valid ? st_nxt.ident[5] : 1'b0;
      res.tag_number     = hdr_valid ? st_nxt.ident[4:0] : 5'd0;
      res.content_length = hdr_valid ? st_nxt.length_acc : 32'h0;
      res.header_length  = hdr_valid ? st_nxt.hdr_len : 3'd0;
      res.last           = last;
   end

endmodule

[hdl/dtp_skid.sv]
// Output register with a skid stage, so the input side only stalls when both are full.
// Depends on dtp_pkg.
module dtp_skid (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  dtp_pkg::result_type in_res,
   output logic                out_valid,
   input  logic                out_stall,
   output dtp_pkg::result_type out_res
);
   import dtp_pkg::*;

   logic       out_valid_ff, out_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type out_res_ff, out_res_in;
   result_type skid_res_ff, skid_res_in;
   logic       take_out;
   logic       accept;
   logic       out_free;

   assign take_out = out_valid_ff && !out_stall;
   assign accept   = in_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || take_out;

   // refill the output register from the skid stage first, then from the input
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_res_in    = out_res_ff;
      skid_valid_in = skid_valid_ff;
      skid_res_in   = skid_res_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_res_in    = skid_res_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = accept;
            out_res_in   = in_res;
         end
      end else if (accept) begin
         skid_valid_in = 1'b1;
         skid_res_in   = in_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_res_ff  <= out_res_in;
      skid_res_ff <= skid_res_in;
   end

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_res   = out_res_ff;

   // a held beat in the skid stage always sits behind a valid output beat
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid beat without output beat");

   // a stalled output beat keeps its value
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_stall |=> out_valid_ff && out_res_ff == $past(out_res_ff))
      else $error("stalled output beat changed");

endmodule

[hdl/der_tlv_stream_parser.sv]
// DER TLV stream parser top level: parser state registers, decode and output buffer.
// Depends on dtp_pkg, dtp_decode and dtp_skid.
// Throughput: one byte per cycle while req_stall is low.
// The parser state register updates every accepted beat; result beats are registered.
// A two-entry output buffer keeps bytes flowing while one result waits on rsp_stall.
// Reset (synchronous): parser expects an identifier byte, strip_zeros is 0, buffer empty.
module der_tlv_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_kind,
   output logic [7:0]  rsp_out_byte,
   output logic [1:0]  rsp_tag_class,
   output logic        rsp_constructed,
   output logic [4:0]  rsp_tag_number,
   output logic [31:0] rsp_content_length,
   output logic [2:0]  rsp_header_length,
   output logic        rsp_last
);
   import dtp_pkg::*;

   logic       strip_zeros_ff;
   state_type  st_ff, st_in;
   result_type dec_res;
   result_type rsp_res;
   logic       req_accept;

   assign req_accept = req_valid && !req_stall;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) begin
         strip_zeros_ff <= 1'b0;
      end else if (csr_wr_en) begin
         strip_zeros_ff <= csr_wr_data;
      end
   end

   dtp_decode u_decode (
      .st          (st_ff),
      .strip_zeros (strip_zeros_ff),
      .data_byte   (req_data_byte),
      .st_nxt      (st_in),
      .res         (dec_res)
   );

   // parser state advances on every accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
      end else if (req_accept) begin
         st_ff <= st_in;
      end
   end

   dtp_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .in_res    (dec_res),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_res   (rsp_res)
   );

   // result fields
   assign rsp_kind           = rsp_res.kind;
   assign rsp_out_byte       = rsp_res.out_byte;
   assign rsp_tag_class      = rsp_res.tag_class;
   assign rsp_constructed    = rsp_res.constructed;
   assign rsp_tag_number     = rsp_res.tag_number;
   assign rsp_content_length = rsp_res.content_length;
   assign rsp_header_length  = rsp_res.header_length;
   assign rsp_last           = rsp_res.last;

   // content phase always has bytes left to consume
   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      st_ff.phase == PH_DATA |-> st_ff.content_left != 32'h0)
      else $error("content phase with no bytes left");

   // errors and plain header bytes carry no decoded header
   a_hdr_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_res.kind == KIND_HDR || rsp_res.kind == KIND_ERR)
      |-> rsp_res.content_length == 32'h0 && rsp_res.header_length == 3'd0)
      else $error("header fields set on header byte or error");

   // a completed element always returns the parser to the identifier phase
   a_last_to_ident: assert property (@(posedge clock) disable iff (reset)
      req_accept && dec_res.last |=> st_ff.phase == PH_IDENT)
      else $error("element end did not return to identifier phase");

   // long-form length counter never exceeds its limit
   a_len_left_range: assert property (@(posedge clock) disable iff (reset)
      st_ff.phase == PH_LENX |-> st_ff.len_left != 3'd0
         && st_ff.len_left <= 3'(MAX_LEN_BYTES))
      else $error("long-form length counter out of range");

endmodule
